// ===== hw/rtl/ratiometric_adc_scaler_averager_macros.svh =====
// Assertion macros used by the top-level RTL file of the ratiometric ADC scaler.
// No dependencies; take in with an include of the bare file name.
`ifndef RATIOMETRIC_ADC_SCALER_AVERAGER_MACROS_SVH
`define RATIOMETRIC_ADC_SCALER_AVERAGER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RASA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define RASA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rasa_pkg.sv =====
// Package for the ratiometric ADC scaler: widths, register indexes, shared types.
// No dependencies; every RTL module and interface imports it.
package rasa_pkg;

    localparam int CHANNELS       = 6;
    localparam int CH_W           = 3;
    localparam int RAW_W          = 12;
    localparam int VREF_W         = 22;
    localparam int AVG_W          = 16;
    localparam int SUM_W          = 48;
    localparam int OUT_W          = 32;
    localparam int FS_W           = 16;
    localparam int PROD_W         = FS_W + VREF_W;
    localparam int FULL_SCALE_DEF = 4095;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_VREF_UV   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_COUNT = 4'd1;

    localparam logic [VREF_W-1:0] VREF_UV_RST   = 22'd1200000;
    localparam logic [AVG_W-1:0]  AVG_COUNT_RST = 16'd16;

    // Shared divider: 48-bit numerator, 16-bit divisor, 4 quotient bits a cycle.
    localparam int DIV_NUM_W  = SUM_W;
    localparam int DIV_DEN_W  = AVG_W;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = DIV_NUM_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } rasa_div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } rasa_div_rsp_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [OUT_W-1:0] avg;
    } rasa_entry_t;

    typedef struct packed {
        logic              rd_en;
        logic [CH_W-1:0]   rd_addr;
        logic              we;
        logic [CH_W-1:0]   wr_addr;
        rasa_entry_t       wr_data;
    } rasa_mem_req_t;

    function automatic logic [OUT_W-1:0] sat32(input logic [SUM_W-1:0] v);
        if (v[SUM_W-1:OUT_W] != '0)
            return '1;
        return v[OUT_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/rasa_cfg_if.sv =====
// Configuration write channel of the ratiometric ADC scaler.
// Depends on rasa_pkg.
interface rasa_cfg_if;
    import rasa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rasa_scan_if.sv =====
// Scan input channel: reference sample plus five channel samples.
// Depends on rasa_pkg.
interface rasa_scan_if;
    import rasa_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_vref;
    logic [RAW_W-1:0] raw_ch1;
    logic [RAW_W-1:0] raw_ch2;
    logic [RAW_W-1:0] raw_ch3;
    logic [RAW_W-1:0] raw_ch4;
    logic [RAW_W-1:0] raw_ch5;

    modport source (output valid, raw_vref, raw_ch1, raw_ch2, raw_ch3, raw_ch4, raw_ch5,
                    input ready);
    modport sink   (input valid, raw_vref, raw_ch1, raw_ch2, raw_ch3, raw_ch4, raw_ch5,
                    output ready);
endinterface

// ===== hw/rtl/rasa_result_if.sv =====
// Result channel: one beat per channel of a scan.
// Depends on rasa_pkg.
interface rasa_result_if;
    import rasa_pkg::*;

    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  channel;
    logic [OUT_W-1:0] voltage_uv;
    logic [OUT_W-1:0] average_uv;
    logic             average_new;
    logic [OUT_W-1:0] supply_uv;
    logic             vref_fault;
    logic             last;

    modport source (output valid, channel, voltage_uv, average_uv, average_new, supply_uv,
                    vref_fault, last, input ready);
    modport sink   (input valid, channel, voltage_uv, average_uv, average_new, supply_uv,
                    vref_fault, last, output ready);
endinterface

// ===== hw/rtl/rasa_div.sv =====
// Shared restoring divider, 4 quotient bits per cycle.
// Depends on rasa_pkg.
module rasa_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rasa_pkg::rasa_div_req_t req,
    output rasa_pkg::rasa_div_rsp_t rsp
);
    import rasa_pkg::*;

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   trial;

    // Radix-16 step built from four restoring steps.
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            trial    = {rem_next, quo_next[DIV_NUM_W-1]};
            quo_next = {quo_next[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = DIV_DEN_W'(trial - {1'b0, den_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DIV_DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
endmodule

// ===== hw/rtl/rasa_state_mem.sv =====
// Per-channel state memory: running sum and latest average, one word per channel.
// Depends on rasa_pkg. Read data is registered; entries read as zero until written.
module rasa_state_mem (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rasa_pkg::rasa_mem_req_t req,
    output rasa_pkg::rasa_entry_t   rd_data
);
    import rasa_pkg::*;

    rasa_entry_t         mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;
    rasa_entry_t         rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (req.we)
            valid_reg[req.wr_addr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.wr_addr] <= req.wr_data;
        if (req.rd_en)
            rd_data_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== hw/rtl/ratiometric_adc_scaler_averager.sv =====
// Top level of the ratiometric ADC scaler with block averaging.
// Depends on rasa_pkg, the three channel interfaces, rasa_div, rasa_state_mem, macros header.
//
//   channel  | dir | beat carries
//   ---------+-----+-------------------------------------------------
//   cfg      | in  | register index, write data (vref_uv, avg_count)
//   scan     | in  | raw_vref, raw_ch1 .. raw_ch5
//   result   | out | channel, voltage_uv, average_uv, average_new,
//            |     | supply_uv, vref_fault, last
//
// A scan uses the shared divider once for the supply and once per channel; a
// scan that closes a block adds one more division per channel. Reset clears
// the sum/average memory through per-entry valid bits at once; no clearing
// pass. A scan beat is buffered while the previous one works, and a stalled
// result beat holds the sequencer in place, never drops work.
`include "ratiometric_adc_scaler_averager_macros.svh"

module ratiometric_adc_scaler_averager #(
    parameter int unsigned FULL_SCALE = rasa_pkg::FULL_SCALE_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rasa_cfg_if.sink      cfg,
    rasa_scan_if.sink     scan,
    rasa_result_if.source result
);
    import rasa_pkg::*;

    localparam logic [FS_W-1:0] FULL_SCALE_V = FS_W'(FULL_SCALE);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUP_MUL,
        S_SUP_START,
        S_SUP_WAIT,
        S_CH_MUL,
        S_CH_START,
        S_CH_WAIT,
        S_CH_SUM,
        S_AVG_START,
        S_AVG_WAIT,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [VREF_W-1:0] vref_uv_reg;
    logic [AVG_W-1:0]  avg_count_reg;

    // Input buffer: take the next scan while this one works.
    logic             buf_valid_reg, buf_valid_next;
    logic [RAW_W-1:0] buf_raw_reg [CHANNELS];
    logic             buf_load;

    // Working registers of the scan in flight.
    logic [RAW_W-1:0]  raw_reg [CHANNELS];
    logic              raw_load;
    logic              fault_reg, fault_next;
    logic              fresh_reg, fresh_next;
    logic [AVG_W-1:0]  divisor_reg, divisor_next;
    logic [AVG_W-1:0]  scans_reg, scans_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [OUT_W-1:0]  supply_reg, supply_next;
    logic [OUT_W-1:0]  volt_reg, volt_next;
    logic [OUT_W-1:0]  avg_reg, avg_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;

    // Output register.
    logic             out_valid_reg, out_valid_next;
    logic [CH_W-1:0]  out_ch_reg, out_ch_next;
    logic [OUT_W-1:0] out_volt_reg, out_volt_next;
    logic [OUT_W-1:0] out_avg_reg, out_avg_next;
    logic             out_new_reg, out_new_next;
    logic [OUT_W-1:0] out_sup_reg, out_sup_next;
    logic             out_fault_reg, out_fault_next;
    logic             out_last_reg, out_last_next;

    logic [AVG_W:0]   cnt_inc;
    logic [AVG_W-1:0] div_eff;
    logic             out_free;

    rasa_div_req_t div_req;
    rasa_div_rsp_t div_rsp;
    rasa_mem_req_t mem_req;
    rasa_entry_t   mem_rd;

    rasa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rasa_state_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (mem_rd)
    );

    // Configuration: always ready, masked to register width, unknown indexes drop.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vref_uv_reg   <= VREF_UV_RST;
            avg_count_reg <= AVG_COUNT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_VREF_UV:   vref_uv_reg   <= cfg.data[VREF_W-1:0];
                REG_AVG_COUNT: avg_count_reg <= cfg.data[AVG_W-1:0];
                default:       ;
            endcase
        end
    end

    assign scan.ready = !buf_valid_reg;
    assign buf_load   = scan.valid && !buf_valid_reg;
    assign out_free   = !out_valid_reg || result.ready;

    // Block bookkeeping: zero avg_count acts as one.
    assign div_eff = (avg_count_reg == '0) ? AVG_W'(1) : avg_count_reg;
    assign cnt_inc = {1'b0, scans_reg} + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        buf_valid_next = buf_valid_reg;
        raw_load       = 1'b0;
        fault_next     = fault_reg;
        fresh_next     = fresh_reg;
        divisor_next   = divisor_reg;
        scans_next     = scans_reg;
        ch_next        = ch_reg;
        supply_next    = supply_reg;
        volt_next      = volt_reg;
        avg_next       = avg_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_ch_next    = out_ch_reg;
        out_volt_next  = out_volt_reg;
        out_avg_next   = out_avg_reg;
        out_new_next   = out_new_reg;
        out_sup_next   = out_sup_reg;
        out_fault_next = out_fault_reg;
        out_last_next  = out_last_reg;
        div_req        = '0;
        mem_req        = '0;

        if (buf_load)
            buf_valid_next = 1'b1;
        if (result.valid && result.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (buf_valid_reg)
                begin
                    raw_load       = 1'b1;
                    buf_valid_next = 1'b0;
                    fault_next     = (buf_raw_reg[0] == '0);
                    divisor_next   = div_eff;
                    fresh_next     = (cnt_inc >= {1'b0, div_eff});
                    scans_next     = (cnt_inc >= {1'b0, div_eff}) ? '0 : cnt_inc[AVG_W-1:0];
                    ch_next        = '0;
                    state_next     = S_SUP_MUL;
                end
            end
            S_SUP_MUL:
            begin
                prod_next  = PROD_W'(FULL_SCALE_V) * PROD_W'(vref_uv_reg);
                state_next = S_SUP_START;
            end
            S_SUP_START:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NUM_W'(prod_reg);
                div_req.den   = DIV_DEN_W'(raw_reg[0]);
                state_next    = S_SUP_WAIT;
            end
            S_SUP_WAIT:
            begin
                if (div_rsp.done)
                begin
                    supply_next = fault_reg ? '0 : sat32(div_rsp.quot);
                    state_next  = S_CH_MUL;
                end
            end
            S_CH_MUL:
            begin
                // Multiply and fetch this channel's state word together.
                prod_next       = PROD_W'(raw_reg[ch_reg]) * PROD_W'(vref_uv_reg);
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ch_reg;
                state_next      = S_CH_START;
            end
            S_CH_START:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NUM_W'(prod_reg);
                div_req.den   = DIV_DEN_W'(raw_reg[0]);
                state_next    = S_CH_WAIT;
            end
            S_CH_WAIT:
            begin
                if (div_rsp.done)
                begin
                    volt_next  = fault_reg ? '0 : sat32(div_rsp.quot);
                    state_next = S_CH_SUM;
                end
            end
            S_CH_SUM:
            begin
                sum_next = mem_rd.sum + SUM_W'(volt_reg);
                if (fresh_reg)
                begin
                    state_next = S_AVG_START;
                end
                else
                begin
                    // Write back the running sum, keep the old average.
                    mem_req.we          = 1'b1;
                    mem_req.wr_addr     = ch_reg;
                    mem_req.wr_data.sum = mem_rd.sum + SUM_W'(volt_reg);
                    mem_req.wr_data.avg = mem_rd.avg;
                    avg_next            = mem_rd.avg;
                    state_next          = S_EMIT;
                end
            end
            S_AVG_START:
            begin
                div_req.start = 1'b1;
                div_req.num   = sum_reg;
                div_req.den   = divisor_reg;
                state_next    = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // Close the block: clear the sum, store the new average.
                    mem_req.we          = 1'b1;
                    mem_req.wr_addr     = ch_reg;
                    mem_req.wr_data.sum = '0;
                    mem_req.wr_data.avg = sat32(div_rsp.quot);
                    avg_next            = sat32(div_rsp.quot);
                    state_next          = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = ch_reg;
                    out_volt_next  = volt_reg;
                    out_avg_next   = avg_reg;
                    out_new_next   = fresh_reg;
                    out_sup_next   = supply_reg;
                    out_fault_next = fault_reg;
                    out_last_next  = (ch_reg == CH_W'(CHANNELS - 1));
                    if (ch_reg == CH_W'(CHANNELS - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_CH_MUL;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            scans_reg     <= '0;
            ch_reg        <= '0;
            fault_reg     <= 1'b0;
            fresh_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_valid_reg <= buf_valid_next;
            out_valid_reg <= out_valid_next;
            scans_reg     <= scans_next;
            ch_reg        <= ch_next;
            fault_reg     <= fault_next;
            fresh_reg     <= fresh_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        if (buf_load)
        begin
            buf_raw_reg[0] <= scan.raw_vref;
            buf_raw_reg[1] <= scan.raw_ch1;
            buf_raw_reg[2] <= scan.raw_ch2;
            buf_raw_reg[3] <= scan.raw_ch3;
            buf_raw_reg[4] <= scan.raw_ch4;
            buf_raw_reg[5] <= scan.raw_ch5;
        end
        if (raw_load)
            raw_reg <= buf_raw_reg;
        divisor_reg   <= divisor_next;
        supply_reg    <= supply_next;
        volt_reg      <= volt_next;
        avg_reg       <= avg_next;
        prod_reg      <= prod_next;
        sum_reg       <= sum_next;
        out_ch_reg    <= out_ch_next;
        out_volt_reg  <= out_volt_next;
        out_avg_reg   <= out_avg_next;
        out_new_reg   <= out_new_next;
        out_sup_reg   <= out_sup_next;
        out_fault_reg <= out_fault_next;
        out_last_reg  <= out_last_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.channel     = out_ch_reg;
    assign result.voltage_uv  = out_volt_reg;
    assign result.average_uv  = out_avg_reg;
    assign result.average_new = out_new_reg;
    assign result.supply_uv   = out_sup_reg;
    assign result.vref_fault  = out_fault_reg;
    assign result.last        = out_last_reg;

    `RASA_ASSERT_IMP(a_last_on_final, clk, rst_n, result.valid && result.last, result.channel == CH_W'(CHANNELS - 1), "last beat not on final channel")
    `RASA_ASSERT_IMP(a_fault_zero, clk, rst_n, result.valid && result.vref_fault, result.voltage_uv == '0 && result.supply_uv == '0, "fault beat carries nonzero voltage")
    `RASA_ASSERT_IMP(a_avg_only_fresh, clk, rst_n, state_reg == S_AVG_START, fresh_reg, "average division outside a block end")
    `RASA_ASSERT_NXT(a_div_starts, clk, rst_n, div_req.start, div_rsp.busy, "divider did not take a start")
endmodule
